@@ hdl/fodm_pkg.sv @@
package fodm_pkg;

    // angle and trig resolution
    localparam int ANGLE_BITS     = 16;
    localparam int TRIG_FRAC_BITS = 15;

    // fixed field widths
    localparam int AX_W   = 8;
    localparam int DB_W   = 7;
    localparam int GAIN_W = 10;
    localparam int HEAD_W = 16;
    localparam int VEL_W  = 8;

    // q30 working format of the sine polynomial, one extra bit to hold 1.0
    localparam int Q_FRAC = 30;
    localparam int Q_W    = Q_FRAC + 1;

    // derived datapath widths
    localparam int SAX_W  = AX_W + GAIN_W;
    localparam int TRIG_W = TRIG_FRAC_BITS + 2;

    // odd polynomial of sin(t*pi/2), highest term last
    localparam int N_COEF  = 6;
    localparam int N_CELLS = N_COEF - 1;
    localparam logic [Q_W-1:0] SIN_COEF [N_COEF] = '{
        31'd1686629713, 31'd693598668, 31'd85569306,
        31'd5026995,    31'd172272,    31'd3864
    };

    // register reset values
    localparam logic [DB_W-1:0]   DEADBAND_RST = 7'd5;
    localparam logic [GAIN_W-1:0] GAIN_RST     = 10'd256;

    // register index codes, taken from paddr[2]
    localparam logic REG_DEADBAND = 1'b0;
    localparam logic REG_GAIN     = 1'b1;

    // one trig lane moving down the horner chain
    typedef struct packed {
        logic [Q_W-1:0] t;
        logic [Q_W-1:0] t2;
        logic [Q_W-1:0] acc;
        logic           neg;
    } t_lane;

    // full payload of one horner stage
    typedef struct packed {
        t_lane                    sin_l;
        t_lane                    cos_l;
        logic signed [SAX_W-1:0]  fwd;
        logic signed [SAX_W-1:0]  lat;
    } t_horner;

endpackage

@@ hdl/fodm_horner_cell.sv @@
module fodm_horner_cell
    import fodm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [Q_W-1:0] i_coef,
    input  logic           i_valid,
    input  t_horner        i_data,
    output logic           o_ready,
    output logic           o_valid,
    output t_horner        o_data,
    input  logic           i_ready
);

    logic               r_valid;
    t_horner            r_data;
    t_horner            n_data;
    logic [2*Q_W-1:0]   w_prod_s;
    logic [2*Q_W-1:0]   w_prod_c;

    // acc = coef - acc*t2, floored at zero
    function automatic logic [Q_W-1:0] horner_step(
        input logic [Q_W-1:0]   coef,
        input logic [2*Q_W-1:0] prod
    );
        logic [Q_W-1:0] p;
        p = prod[Q_FRAC+Q_W-1:Q_FRAC];
        return (coef > p) ? coef - p : '0;
    endfunction

    // one multiply per lane
    assign w_prod_s = i_data.sin_l.acc * i_data.sin_l.t2;
    assign w_prod_c = i_data.cos_l.acc * i_data.cos_l.t2;

    always_comb begin
        n_data           = i_data;
        n_data.sin_l.acc = horner_step(i_coef, w_prod_s);
        n_data.cos_l.acc = horner_step(i_coef, w_prod_c);
    end

    // stage loads when empty or when the neighbor takes its contents
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hdl/field_oriented_drive_mix.sv @@
// field oriented drive mixer
// input stream s_axis carries one joystick sample per transaction: forward
// axis, lateral axis (signed percent) and heading as a binary angle. output
// stream m_axis carries left, right and strafe velocities (signed percent,
// saturated to +-100); left and right are always equal.
// the apb port holds the axis deadband (0x0) and the q2.8 speed gain (0x4);
// write them only while no transaction is in flight.
// throughput: one sample per cycle while the receiver keeps m_axis_tready
// high. the pipeline is twelve register stages, five of them a chain of
// horner cells evaluating sine and cosine side by side, each cell one
// multiply wide per lane.
// every stage loads when it is empty or its neighbor loads, so when the
// receiver stalls the results back up stage by stage and s_axis_tready
// drops only once all twelve stages hold a result.
// reset empties the pipeline and returns deadband to 5 and gain to 1.0;
// nothing else needs clearing.
module field_oriented_drive_mix
    import fodm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: forward_axis [7:0], lateral_axis [15:8], heading_angle [31:16]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    // tdata: left_velocity [7:0], right_velocity [15:8], strafe_velocity [23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FRAC_SH = Q_FRAC - (ANGLE_BITS - 2);
    localparam int RND_SH  = Q_FRAC - TRIG_FRAC_BITS;
    localparam int PROD_W  = SAX_W + TRIG_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int OUT_SH  = 8 + TRIG_FRAC_BITS;
    localparam int Q_RW    = SUM_W + 1 - OUT_SH;
    localparam int VEL_LIMIT = 100;

    localparam logic [Q_W-1:0]        Q_ONE     = {1'b1, {Q_FRAC{1'b0}}};
    localparam logic [ANGLE_BITS-1:0] QUARTER   = {2'b01, {(ANGLE_BITS - 2){1'b0}}};
    localparam logic [Q_W:0]          TRIG_HALF = {{Q_W{1'b0}}, 1'b1} << (RND_SH - 1);
    localparam logic [TRIG_W-1:0]     TRIG_ONE  =
        {{(TRIG_W - 1){1'b0}}, 1'b1} << TRIG_FRAC_BITS;
    localparam logic [SUM_W:0]        OUT_HALF  = {{SUM_W{1'b0}}, 1'b1} << (OUT_SH - 1);

    // configuration registers
    logic [DB_W-1:0]   r_deadband;
    logic [GAIN_W-1:0] r_gain;
    logic              w_cfg_wr;

    // stage enables, input side first
    logic w_en_a, w_en_b, w_en_d, w_en_e, w_en_p, w_en_s, w_en_o;

    // stage a: shaped axes and split angles
    logic                    r_va;
    t_horner                 r_a;
    t_horner                 n_a;
    logic signed [AX_W-1:0]  w_fwd_raw;
    logic signed [AX_W-1:0]  w_lat_raw;
    logic [ANGLE_BITS-1:0]   w_ang_s;
    logic [ANGLE_BITS-1:0]   w_ang_c;

    // stage b: t squared
    logic                    r_vb;
    t_horner                 r_b;
    t_horner                 n_b;
    logic [2*Q_W-1:0]        w_t2_s;
    logic [2*Q_W-1:0]        w_t2_c;

    // horner chain
    logic                    w_cvalid [N_CELLS+1];
    logic                    w_cready [N_CELLS+1];
    t_horner                 w_cdata  [N_CELLS+1];

    // stage d: last multiply by t
    logic                    r_vd;
    logic [Q_W-1:0]          r_sraw_s, r_sraw_c;
    logic                    r_neg_s, r_neg_c;
    logic signed [SAX_W-1:0] r_fwd_d, r_lat_d;
    logic [2*Q_W-1:0]        w_fin_s, w_fin_c;

    // stage e: rounded trig values
    logic                     r_ve;
    logic signed [TRIG_W-1:0] r_sin, r_cos;
    logic signed [SAX_W-1:0]  r_fwd_e, r_lat_e;

    // stage p: products
    logic                     r_vp;
    logic signed [PROD_W-1:0] r_fc, r_ls, r_lc, r_fs;

    // stage s: sums
    logic                     r_vs;
    logic signed [SUM_W-1:0]  r_drive, r_strafe;

    // stage o: output register
    logic                     r_vo;
    logic [VEL_W-1:0]         r_vel, r_strafe_vel;

    // zero inside the deadband, else scale by the gain
    function automatic logic signed [SAX_W-1:0] shape_axis(
        input logic signed [AX_W-1:0] v,
        input logic [DB_W-1:0]        db,
        input logic [GAIN_W-1:0]      g
    );
        logic [AX_W-1:0]        mag;
        logic signed [SAX_W:0]  prod;
        mag  = v[AX_W-1] ? AX_W'(-v) : AX_W'(v);
        prod = v * $signed({1'b0, g});
        return (mag > {1'b0, db}) ? prod[SAX_W-1:0] : '0;
    endfunction

    // quadrant and quarter-turn fraction in q30
    function automatic t_lane split_angle(input logic [ANGLE_BITS-1:0] a);
        t_lane          r;
        logic [Q_W-1:0] t;
        r = '0;
        t = Q_W'(a[ANGLE_BITS-3:0]) << FRAC_SH;
        if (a[ANGLE_BITS-2]) begin
            t = Q_ONE - t;
        end
        r.t   = t;
        r.neg = a[ANGLE_BITS-1];
        return r;
    endfunction

    // round half up to trig precision, clamp at 1.0, apply sign
    function automatic logic signed [TRIG_W-1:0] trig_round(
        input logic [Q_W-1:0] s,
        input logic           neg
    );
        logic [Q_W:0]      sum;
        logic [TRIG_W-1:0] q;
        sum = {1'b0, s} + TRIG_HALF;
        q   = sum[Q_W:RND_SH];
        if (q > TRIG_ONE) begin
            q = TRIG_ONE;
        end
        return neg ? $signed(-q) : $signed(q);
    endfunction

    // round to whole percent, ties away from zero, saturate
    function automatic logic [VEL_W-1:0] vel_round(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] m;
        logic [SUM_W:0]   r;
        logic [Q_RW-1:0]  q;
        logic [VEL_W-1:0] mq;
        m  = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
        r  = {1'b0, m} + OUT_HALF;
        q  = r[SUM_W:OUT_SH];
        mq = (q > Q_RW'(VEL_LIMIT)) ? VEL_W'(VEL_LIMIT) : VEL_W'(q);
        return v[SUM_W-1] ? -mq : mq;
    endfunction

    // apb register writes
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= DEADBAND_RST;
            r_gain     <= GAIN_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_DEADBAND: r_deadband <= pwdata[DB_W-1:0];
                REG_GAIN:     r_gain     <= pwdata[GAIN_W-1:0];
                default:      r_gain     <= r_gain;
            endcase
        end
    end

    // apb read mux
    always_comb begin
        unique case (paddr[2])
            REG_DEADBAND: prdata = 32'(r_deadband);
            REG_GAIN:     prdata = 32'(r_gain);
            default:      prdata = '0;
        endcase
    end

    // enable chain: a stage loads when empty or when the next one loads
    assign w_en_o = !r_vo || m_axis_tready;
    assign w_en_s = !r_vs || w_en_o;
    assign w_en_p = !r_vp || w_en_s;
    assign w_en_e = !r_ve || w_en_p;
    assign w_en_d = !r_vd || w_en_e;
    assign w_en_b = !r_vb || w_cready[0];
    assign w_en_a = !r_va || w_en_b;
    assign s_axis_tready = w_en_a;

    // stage a
    assign w_fwd_raw = s_axis_tdata[7:0];
    assign w_lat_raw = s_axis_tdata[15:8];
    assign w_ang_s   = ANGLE_BITS'(s_axis_tdata[2*AX_W +: HEAD_W]);
    assign w_ang_c   = w_ang_s + QUARTER;

    always_comb begin
        n_a.sin_l = split_angle(w_ang_s);
        n_a.cos_l = split_angle(w_ang_c);
        n_a.fwd   = shape_axis(w_fwd_raw, r_deadband, r_gain);
        n_a.lat   = shape_axis(w_lat_raw, r_deadband, r_gain);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_en_a) begin
            r_va <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a <= n_a;
        end
    end

    // stage b
    assign w_t2_s = r_a.sin_l.t * r_a.sin_l.t;
    assign w_t2_c = r_a.cos_l.t * r_a.cos_l.t;

    always_comb begin
        n_b           = r_a;
        n_b.sin_l.t2  = w_t2_s[Q_FRAC+Q_W-1:Q_FRAC];
        n_b.cos_l.t2  = w_t2_c[Q_FRAC+Q_W-1:Q_FRAC];
        n_b.sin_l.acc = SIN_COEF[N_COEF-1];
        n_b.cos_l.acc = SIN_COEF[N_COEF-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_en_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            r_b <= n_b;
        end
    end

    // horner cells, highest coefficient first
    assign w_cvalid[0]       = r_vb;
    assign w_cdata[0]        = r_b;
    assign w_cready[N_CELLS] = w_en_d;

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        fodm_horner_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_coef  (SIN_COEF[N_CELLS-1-k]),
            .i_valid (w_cvalid[k]),
            .i_data  (w_cdata[k]),
            .o_ready (w_cready[k]),
            .o_valid (w_cvalid[k+1]),
            .o_data  (w_cdata[k+1]),
            .i_ready (w_cready[k+1])
        );
    end

    // stage d
    assign w_fin_s = w_cdata[N_CELLS].sin_l.acc * w_cdata[N_CELLS].sin_l.t;
    assign w_fin_c = w_cdata[N_CELLS].cos_l.acc * w_cdata[N_CELLS].cos_l.t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (w_en_d) begin
            r_vd <= w_cvalid[N_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_d) begin
            r_sraw_s <= w_fin_s[Q_FRAC+Q_W-1:Q_FRAC];
            r_sraw_c <= w_fin_c[Q_FRAC+Q_W-1:Q_FRAC];
            r_neg_s  <= w_cdata[N_CELLS].sin_l.neg;
            r_neg_c  <= w_cdata[N_CELLS].cos_l.neg;
            r_fwd_d  <= w_cdata[N_CELLS].fwd;
            r_lat_d  <= w_cdata[N_CELLS].lat;
        end
    end

    // stage e
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (w_en_e) begin
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_e) begin
            r_sin   <= trig_round(r_sraw_s, r_neg_s);
            r_cos   <= trig_round(r_sraw_c, r_neg_c);
            r_fwd_e <= r_fwd_d;
            r_lat_e <= r_lat_d;
        end
    end

    // stage p
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (w_en_p) begin
            r_vp <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_p) begin
            r_fc <= r_fwd_e * r_cos;
            r_ls <= r_lat_e * r_sin;
            r_lc <= r_lat_e * r_cos;
            r_fs <= r_fwd_e * r_sin;
        end
    end

    // stage s
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= 1'b0;
        end else if (w_en_s) begin
            r_vs <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_s) begin
            r_drive  <= SUM_W'(r_fc) + SUM_W'(r_ls);
            r_strafe <= SUM_W'(r_lc) - SUM_W'(r_fs);
        end
    end

    // stage o
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_en_o) begin
            r_vo <= r_vs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_o) begin
            r_vel        <= vel_round(r_drive);
            r_strafe_vel <= vel_round(r_strafe);
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {r_strafe_vel, r_vel, r_vel};

`ifndef SYNTH
    // an accepted sample always lands in the first stage
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_va)
        else $error("accepted sample not captured");

    // with the output register empty nothing upstream may block
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // results are saturated and left equals right
    a_vel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[7:0]) <= 8'sd100
            && $signed(m_axis_tdata[7:0]) >= -8'sd100
            && $signed(m_axis_tdata[23:16]) <= 8'sd100
            && $signed(m_axis_tdata[23:16]) >= -8'sd100
            && m_axis_tdata[7:0] == m_axis_tdata[15:8]))
        else $error("velocity out of range or sides differ");

    // a deadband write takes effect on the next cycle
    a_cfg_deadband: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && paddr[2] == REG_DEADBAND) |=> r_deadband == $past(pwdata[DB_W-1:0]))
        else $error("deadband write lost");
`endif

endmodule

@@ dv/tb_field_oriented_drive_mix.sv @@
module tb_field_oriented_drive_mix;
    timeunit 1ns;
    timeprecision 1ps;
    import fodm_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 60;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int STRETCH      = 40;
    localparam int N_DIRECTED   = 22;

    // register byte addresses, index bit sits at paddr[2]
    localparam logic [2:0] ADDR_DEADBAND = {REG_DEADBAND, 2'b00};
    localparam logic [2:0] ADDR_GAIN     = {REG_GAIN, 2'b00};

    // q30 terms of the quarter-turn sine polynomial, lowest power first
    localparam longint unsigned SINE_POLY [6] = '{
        64'd1686629713, 64'd693598668, 64'd85569306,
        64'd5026995,    64'd172272,    64'd3864
    };
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned TRIG_ONE = 64'd1 << 15;

    // per-phase register settings; random_cfg picks fresh values instead
    localparam int PH_DEADBAND   [N_PHASES] = '{0, 100, 127, 5, 1, 0, 20, 0};
    localparam int PH_GAIN       [N_PHASES] = '{512, 0, 1023, 256, 1, 0, 384, 0};
    localparam bit PH_RANDOM_CFG [N_PHASES] = '{0, 0, 0, 0, 0, 1, 0, 1};
    localparam bit PH_HOLD       [N_PHASES] = '{0, 0, 0, 1, 0, 0, 1, 0};

    // one velocity result, left in the low byte as on m_axis_tdata
    typedef struct packed {
        logic signed [7:0] strafe;
        logic signed [7:0] right;
        logic signed [7:0] left;
    } velocity_t;

    // one row of the directed table; drive and strafe used only when typed
    typedef struct packed {
        logic signed [7:0] fwd;
        logic signed [7:0] lat;
        logic [15:0]       head;
        bit                typed;
        logic signed [7:0] drive;
        logic signed [7:0] strafe;
    } sample_row_t;

    // directed samples at reset settings (deadband 5, gain 1.0)
    localparam sample_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{0,    0,    16'h0000, 1, 0,    0},
        '{100,  0,    16'h0000, 1, 100,  0},
        '{-100, 0,    16'h0000, 1, -100, 0},
        '{0,    100,  16'h0000, 1, 0,    100},
        '{0,    -100, 16'h0000, 1, 0,    -100},
        '{100,  0,    16'h4000, 1, 0,    -100},
        '{100,  0,    16'h8000, 1, -100, 0},
        '{100,  0,    16'hC000, 1, 0,    100},
        '{0,    100,  16'h4000, 1, 100,  0},
        '{5,    -5,   16'h0000, 1, 0,    0},
        '{6,    -6,   16'h0000, 1, 6,    -6},
        '{-6,   6,    16'h0000, 1, -6,   6},
        '{127,  -128, 16'h0000, 1, 100,  -100},
        '{-128, 127,  16'h0000, 1, -100, 100},
        '{100,  100,  16'h2000, 0, 0,    0},
        '{-100, 100,  16'h6000, 0, 0,    0},
        '{50,   -70,  16'hFFFF, 0, 0,    0},
        '{37,   -83,  16'h5555, 0, 0,    0},
        '{-99,  64,   16'hAAAA, 0, 0,    0},
        '{100,  -100, 16'h8001, 0, 0,    0},
        '{7,    7,    16'h3FFF, 0, 0,    0},
        '{-7,   100,  16'hC001, 0, 0,    0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // shadow copy of the block's registers
    logic [DB_W-1:0]   cfg_deadband;
    logic [GAIN_W-1:0] cfg_gain;

    velocity_t expected_vel_q [$];
    int        mismatch_count;
    bit        sender_idle_on;
    bit        sink_idle_on;
    bit        hold_request;

    field_oriented_drive_mix uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // sine of t * pi/2 for a quarter-turn fraction t in q30
    function automatic longint unsigned quarter_sine_q30(longint unsigned t);
        longint unsigned t2;
        longint unsigned acc;
        longint unsigned p;
        int k;
        t2  = (t * t) >> 30;
        acc = SINE_POLY[5];
        for (k = 4; k >= 0; k--) begin
            p   = (acc * t2) >> 30;
            acc = (SINE_POLY[k] > p) ? SINE_POLY[k] - p : 64'd0;
        end
        return (acc * t) >> 30;
    endfunction

    // sine of a 16-bit binary angle, 15 fraction bits, clamped to +-1.0
    function automatic longint bam_sine(logic [15:0] ang);
        longint unsigned t;
        longint unsigned s;
        t = longint'(ang[13:0]) << 16;
        if (ang[14]) begin
            t = Q30_ONE - t;
        end
        s = quarter_sine_q30(t);
        s = (s + (64'd1 << 14)) >> 15;
        if (s > TRIG_ONE) begin
            s = TRIG_ONE;
        end
        return ang[15] ? -longint'(s) : longint'(s);
    endfunction

    // deadband then q2.8 gain
    function automatic longint scale_axis(logic [7:0] raw);
        longint v;
        longint mag;
        v   = longint'(signed'(raw));
        mag = (v < 0) ? -v : v;
        if (mag > longint'(cfg_deadband)) begin
            return v * longint'(cfg_gain);
        end
        return 0;
    endfunction

    // drop 23 fraction bits, ties away from zero, clamp to +-100
    function automatic logic signed [7:0] round_velocity(longint v);
        longint m;
        bit     neg;
        neg = (v < 0);
        m   = neg ? -v : v;
        m   = (m + (64'sd1 <<< 22)) >>> 23;
        if (m > 100) begin
            m = 100;
        end
        return neg ? 8'(-m) : 8'(m);
    endfunction

    // rotate the shaped joystick vector by the heading
    function automatic velocity_t predict_velocity(logic [7:0] fwd, logic [7:0] lat,
                                                   logic [15:0] head);
        longint    f;
        longint    l;
        longint    s;
        longint    c;
        velocity_t v;
        f = scale_axis(fwd);
        l = scale_axis(lat);
        s = bam_sine(head);
        c = bam_sine(16'(head + 16'h4000));
        v.left   = round_velocity(f * c + l * s);
        v.right  = v.left;
        v.strafe = round_velocity(l * c - f * s);
        return v;
    endfunction

    // axis value: mostly in range, some near the deadband, some any byte
    function automatic logic [7:0] rand_axis();
        int pick;
        int mag;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 8'($urandom);
        end
        if (pick <= 2) begin
            mag = int'(cfg_deadband) + int'($urandom_range(0, 4)) - 2;
            if (mag < 0) mag = 0;
            if (mag > 127) mag = 127;
            return ($urandom_range(0, 1) != 0) ? 8'(-mag) : 8'(mag);
        end
        if (pick == 3) begin
            return ($urandom_range(0, 1) != 0) ? 8'(100) : 8'(-100);
        end
        return 8'(int'($urandom_range(0, 200)) - 100);
    endfunction

    // heading: mostly uniform, some right at quadrant boundaries
    function automatic logic [15:0] rand_heading();
        logic [15:0] base;
        if ($urandom_range(0, 4) == 0) begin
            base = {2'($urandom_range(0, 3)), 14'd0};
            return 16'(base + 16'($urandom_range(0, 4)) - 16'd2);
        end
        return 16'($urandom);
    endfunction

    // apb transfer, left with psel high; caller releases the bus
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[2] == REG_DEADBAND) begin
            cfg_deadband = data[DB_W-1:0];
        end else begin
            cfg_gain = data[GAIN_W-1:0];
        end
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register 0x%0h read expected 0x%0h got 0x%0h",
                     $time, addr, want, prdata);
            mismatch_count++;
        end
    endtask

    // write both registers, read them back, release the bus
    task automatic configure(input logic [31:0] db_word, input logic [31:0] gain_word);
        apb_write(ADDR_DEADBAND, db_word);
        apb_write(ADDR_GAIN, gain_word);
        apb_read_check(ADDR_DEADBAND, 32'(cfg_deadband));
        apb_read_check(ADDR_GAIN, 32'(cfg_gain));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // offer one sample, after a random gap when sender idles are on, and log its expected velocities
    task automatic send_sample(input logic [7:0] fwd, input logic [7:0] lat,
                               input logic [15:0] head, input bit typed,
                               input velocity_t typed_vel);
        int gap;
        gap = sender_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {head, lat, fwd};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_vel_q.push_back(typed ? typed_vel : predict_velocity(fwd, lat, head));
    endtask

    // wait until every expected result is back, then let the pipeline settle
    task automatic drain();
        while (expected_vel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stalls, one long hold on request, field checks
    initial begin
        int        stall;
        velocity_t got;
        velocity_t want;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = sink_idle_on ? $urandom_range(0, 8) : 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = m_axis_tdata;
            if (expected_vel_q.size() == 0) begin
                $display("%0t: unexpected result transaction 0x%06h", $time, got);
                mismatch_count++;
            end else begin
                want = expected_vel_q.pop_front();
                if (got.left !== want.left) begin
                    $display("%0t: left_velocity expected %0d got %0d",
                             $time, want.left, got.left);
                    mismatch_count++;
                end
                if (got.right !== want.right) begin
                    $display("%0t: right_velocity expected %0d got %0d",
                             $time, want.right, got.right);
                    mismatch_count++;
                end
                if (got.strafe !== want.strafe) begin
                    $display("%0t: strafe_velocity expected %0d got %0d",
                             $time, want.strafe, got.strafe);
                    mismatch_count++;
                end
            end
        end
    end

    // main sequence: reset, directed table, random phases
    initial begin
        int          i;
        int          p;
        int          n;
        sample_row_t row;
        velocity_t   row_vel;
        logic [31:0] db_word;
        logic [31:0] gain_word;
        mismatch_count = 0;
        hold_request   = 1'b0;
        sender_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        cfg_deadband   = DEADBAND_RST;
        cfg_gain       = GAIN_RST;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values
        apb_read_check(ADDR_DEADBAND, 32'(DEADBAND_RST));
        apb_read_check(ADDR_GAIN, 32'(GAIN_RST));
        psel    <= 1'b0;
        penable <= 1'b0;

        // directed table
        for (i = 0; i < N_DIRECTED; i++) begin
            row            = DIRECTED_ROWS[i];
            row_vel.left   = row.drive;
            row_vel.right  = row.drive;
            row_vel.strafe = row.strafe;
            send_sample(row.fwd, row.lat, row.head, row.typed, row_vel);
        end
        s_axis_tvalid <= 1'b0;

        // random phases, each at its own register setting
        for (p = 0; p < N_PHASES; p++) begin
            drain();
            if (PH_RANDOM_CFG[p]) begin
                db_word   = {$urandom_range(0, 1) != 0 ? 25'($urandom) : 25'd0,
                             7'($urandom_range(0, 127))};
                gain_word = {$urandom_range(0, 1) != 0 ? 22'($urandom) : 22'd0,
                             10'($urandom_range(0, 1023))};
            end else begin
                db_word   = 32'(PH_DEADBAND[p]);
                gain_word = 32'(PH_GAIN[p]);
            end
            configure(db_word, gain_word);
            hold_request = PH_HOLD[p];
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % STRETCH == 0) begin
                    sender_idle_on = !PH_HOLD[p] && ($urandom_range(0, 3) != 0);
                    sink_idle_on   = !PH_HOLD[p] && ($urandom_range(0, 3) != 0);
                end
                send_sample(rand_axis(), rand_axis(), rand_heading(), 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
        end

        drain();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/fodm_pkg.sv
hdl/fodm_horner_cell.sv
hdl/field_oriented_drive_mix.sv
dv/tb_field_oriented_drive_mix.sv
